/* hdl/usd_pkg.sv */
`timescale 1ns / 1ps

package usd_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int NAME_BYTES  = 100;
  localparam int SIZE_DIGITS = 12;
  localparam int SIZE_OFFSET = 124;

  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int SIZE_W = 36;
  localparam int KIND_W = 3;

  localparam logic [OFF_W-1:0] LAST_OFF   = OFF_W'(BLOCK_BYTES - 1);
  localparam logic [OFF_W-1:0] NAME_END   = OFF_W'(NAME_BYTES);
  localparam logic [OFF_W-1:0] SIZE_START = OFF_W'(SIZE_OFFSET);
  localparam logic [OFF_W-1:0] SIZE_END   = OFF_W'(SIZE_OFFSET + SIZE_DIGITS);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;

  typedef enum logic [KIND_W-1:0] {
    K_NAME  = 3'd0,
    K_HDR   = 3'd1,
    K_DATA  = 3'd2,
    K_END   = 3'd3,
    K_TRUNC = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       final_req;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        value;
    logic [SIZE_W-1:0] entry_size;
    logic              entry_last;
    logic              archive_end;
  } result_t;

  // flow control between the pipeline stages
  typedef struct packed {
    logic valid;
    logic advance;
  } flow_t;

endpackage

/* hdl/usd_if.sv */
`timescale 1ns / 1ps

interface usd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       final_req;

  modport source (output valid, output byte_req, output final_req, input ready);
  modport sink (input valid, input byte_req, input final_req, output ready);
endinterface

interface usd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  value;
  logic [35:0] entry_size;
  logic        entry_last;
  logic        archive_end;

  modport source (output valid, output kind, output value, output entry_size,
                  output entry_last, output archive_end, input ready);
  modport sink (input valid, input kind, input value, input entry_size,
                input entry_last, input archive_end, output ready);
endinterface

/* hdl/ustar_stream_deframer.sv */
`timescale 1ns / 1ps

// channel   dir  fields                                          handshake
// in_ch     in   byte_req[7:0], final_req                        valid/ready
// out_ch    out  kind[2:0], value[7:0], entry_size[35:0],        valid/ready
//                entry_last, archive_end
//
// one byte per cycle sustained while out_ch is ready; a result reaches out_ch from its byte
// through the input register, then the parse logic into the output register
// bytes that give no result pass through without using an output slot
// synchronous active-low reset returns the parser to the header phase
// a stalled output holds its item; in_ready drops only when both stages are full

module ustar_stream_deframer import usd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  usd_in_if.sink    in_ch,
  usd_out_if.source out_ch
);

  item_t   in_item;
  item_t   s1_item;
  flow_t   s1_flow;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.byte_req  = in_ch.byte_req;
  assign in_item.final_req = in_ch.final_req;

  usd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_flow  (s1_flow),
    .s1_item  (s1_item)
  );

  usd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_flow   (s1_flow),
    .s1_item   (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  usd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind        = out_res.kind;
  assign out_ch.value       = out_res.value;
  assign out_ch.entry_size  = out_res.entry_size;
  assign out_ch.entry_last  = out_res.entry_last;
  assign out_ch.archive_end = out_res.archive_end;

endmodule

/* hdl/usd_in_reg.sv */
`timescale 1ns / 1ps

module usd_in_reg import usd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output flow_t s1_flow,
  output item_t s1_item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_flow.valid   = valid_r;
  assign s1_flow.advance = advance;
  assign s1_item         = item_r;

endmodule

/* hdl/usd_parser.sv */
`timescale 1ns / 1ps

module usd_parser import usd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  flow_t   s1_flow,
  input  item_t   s1_item,
  output logic    res_valid,
  output result_t res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_PAD    = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic              closed_r, closed_nxt;
  logic              az_r, az_nxt;
  logic [SIZE_W-1:0] acc_r, acc_nxt;
  logic              stopped_r, stopped_nxt;
  logic [SIZE_W-1:0] remain_r, remain_nxt;

  logic              fire;
  logic              emit;
  logic              clear_hdr;
  logic              do_restart;
  logic [7:0]        b;
  logic              fin;
  logic [OFF_W-1:0]  off_inc;
  logic [SIZE_W-1:0] rem;
  logic              rem_zero;
  logic              az_upd;
  logic              in_size;
  logic              is_digit;
  logic              stop_upd;
  logic [SIZE_W-1:0] acc_upd;
  logic              in_name;
  logic              name_out;
  logic              closed_upd;

  assign fire = s1_flow.valid && s1_flow.advance;
  assign b    = s1_item.byte_req;
  assign fin  = s1_item.final_req;

  assign off_inc  = off_r + OFF_W'(1);
  assign rem      = (remain_r == '0) ? '0 : remain_r - SIZE_W'(1);
  assign rem_zero = (rem == '0);

  assign az_upd   = az_r && (b == CH_NUL);
  assign in_size  = (off_r >= SIZE_START) && (off_r < SIZE_END) && !stopped_r;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_SEVEN);
  assign stop_upd = stopped_r || (in_size && (b == CH_NUL || b == CH_SPACE));
  // shift in one octal digit, wrapping at the accumulator width
  assign acc_upd  = (in_size && is_digit) ? {acc_r[SIZE_W-4:0], b[2:0]} : acc_r;

  assign in_name    = (off_r < NAME_END) && !closed_r;
  assign name_out   = in_name && (b != CH_NUL);
  assign closed_upd = closed_r || (in_name && (b == CH_NUL));

  always_comb begin
    phase_nxt   = phase_r;
    off_nxt     = off_r;
    closed_nxt  = closed_r;
    az_nxt      = az_r;
    acc_nxt     = acc_r;
    stopped_nxt = stopped_r;
    remain_nxt  = remain_r;
    emit        = 1'b0;
    clear_hdr   = 1'b0;
    do_restart  = 1'b0;
    res.kind        = K_NAME;
    res.value       = 8'h00;
    res.entry_size  = '0;
    res.entry_last  = 1'b0;
    res.archive_end = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        closed_nxt  = closed_upd;
        az_nxt      = az_upd;
        acc_nxt     = acc_upd;
        stopped_nxt = stop_upd;
        if (off_r == LAST_OFF) begin
          emit      = 1'b1;
          clear_hdr = 1'b1;
          priority if (az_upd) begin
            do_restart      = 1'b1;
            phase_nxt       = fin ? PH_HEADER : PH_DONE;
            res.kind        = K_END;
            res.archive_end = 1'b1;
          end else if (fin) begin
            do_restart      = 1'b1;
            phase_nxt       = PH_HEADER;
            res.kind        = (acc_upd == '0) ? K_HDR : K_TRUNC;
            res.archive_end = 1'b1;
          end else begin
            remain_nxt     = acc_upd;
            phase_nxt      = (acc_upd != '0) ? PH_DATA : PH_HEADER;
            res.kind       = K_HDR;
            res.entry_size = acc_upd;
          end
        end else begin
          off_nxt = off_inc;
          priority if (fin) begin
            emit            = 1'b1;
            clear_hdr       = 1'b1;
            do_restart      = 1'b1;
            phase_nxt       = PH_HEADER;
            res.kind        = K_END;
            res.archive_end = 1'b1;
          end else if (name_out) begin
            emit      = 1'b1;
            res.kind  = K_NAME;
            res.value = b;
          end else begin
          end
        end
      end
      PH_DATA: begin
        off_nxt = off_inc;
        emit    = 1'b1;
        if (fin) begin
          clear_hdr       = 1'b1;
          do_restart      = 1'b1;
          phase_nxt       = PH_HEADER;
          res.archive_end = 1'b1;
          if (rem_zero) begin
            res.kind       = K_DATA;
            res.value      = b;
            res.entry_last = 1'b1;
          end else begin
            res.kind = K_TRUNC;
          end
        end else begin
          remain_nxt     = rem;
          res.kind       = K_DATA;
          res.value      = b;
          res.entry_last = rem_zero;
          if (rem_zero) begin
            if (off_inc == '0) begin
              clear_hdr = 1'b1;
              phase_nxt = PH_HEADER;
            end else begin
              phase_nxt = PH_PAD;
            end
          end
        end
      end
      PH_PAD: begin
        off_nxt = off_inc;
        if (fin) begin
          emit            = 1'b1;
          clear_hdr       = 1'b1;
          do_restart      = 1'b1;
          phase_nxt       = PH_HEADER;
          res.kind        = K_END;
          res.archive_end = 1'b1;
        end else if (off_inc == '0) begin
          clear_hdr = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      PH_DONE: begin
        // trailing bytes after the end block are dropped
        if (fin) begin
          clear_hdr  = 1'b1;
          do_restart = 1'b1;
          phase_nxt  = PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    if (clear_hdr) begin
      off_nxt     = '0;
      closed_nxt  = 1'b0;
      az_nxt      = 1'b1;
      acc_nxt     = '0;
      stopped_nxt = 1'b0;
    end
    if (do_restart) begin
      remain_nxt = '0;
    end
  end

  assign res_valid = fire && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      off_r     <= '0;
      closed_r  <= 1'b0;
      az_r      <= 1'b1;
      acc_r     <= '0;
      stopped_r <= 1'b0;
      remain_r  <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      off_r     <= off_nxt;
      closed_r  <= closed_nxt;
      az_r      <= az_nxt;
      acc_r     <= acc_nxt;
      stopped_r <= stopped_nxt;
      remain_r  <= remain_nxt;
    end
  end

  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> remain_r != '0)
    else $error("data phase with no bytes left");

  a_pad_mid_block: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAD |-> off_r != '0)
    else $error("padding phase at a block boundary");

  a_trunc_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == K_TRUNC) |=>
      (phase_r == PH_HEADER && off_r == '0 && remain_r == '0))
    else $error("truncation result without restart");

endmodule

/* hdl/usd_out_reg.sv */
`timescale 1ns / 1ps

module usd_out_reg import usd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> advance)
    else $error("result produced while output register is blocked");

endmodule
